// ===== design/quicksort_int_ascending_top_macros.svh =====
// Assertion macros used by the quicksort block's top-level RTL file.
`ifndef QUICKSORT_INT_ASCENDING_TOP_MACROS_SVH
`define QUICKSORT_INT_ASCENDING_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk and quiet while rst_n is low.
`define QSI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and quiet while rst_n is low.
`define QSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/qsi_pkg.sv =====
// Package with the sizes, types and sequencer states of the quicksort block.
`default_nettype none

package qsi_pkg;

    // Width of the value and sorted_value ports.
    localparam int DATA_BITS   = 32;
    // Set capacity and significant value bits.
    localparam int MAX_ITEMS   = 64;
    localparam int VALUE_BITS  = 32;

    // Storage sizes.
    localparam int STORE_DEPTH = 64;
    localparam int STACK_DEPTH = STORE_DEPTH;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int COUNT_BITS  = ADDR_BITS + 1;
    localparam int RANGE_BITS  = 2 * ADDR_BITS;

    // Stored word: bits above 32 would only be sign copies that the output drops.
    localparam int WORD_BITS   = (VALUE_BITS < DATA_BITS) ? VALUE_BITS : DATA_BITS;

    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [COUNT_BITS-1:0] cnt_t;
    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [RANGE_BITS-1:0] range_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_POP,
        ST_RANGE,
        ST_PIVOT,
        ST_CMP,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_FIN_A,
        ST_FIN_B,
        ST_PUSH_LO,
        ST_PUSH_HI,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== design/quicksort_int_ascending_top.sv =====
// Top level of the quicksort block: loader, partition sequencer and result emitter.
//
//  Channel   | Handshake              | Beat fields
//  ----------+------------------------+-------------------------------------
//  input     | start, busy            | value, is_last
//  result    | strobe (one cycle)     | sorted_value, end_of_run, overflowed
//
// Loading takes one beat per cycle while busy is low; the receiver never stalls results.
// After the closing beat, busy covers the ST_INIT set-up state, the sort and n emission reads.
// Each partition works through the single item RAM, which has one write port and one read port.
// Each result shows in the cycle after its read, so the final beat comes as busy drops.
// Reset is asynchronous; the RAMs need no clearing pass, so the block loads at once.
`default_nettype none
`include "quicksort_int_ascending_top_macros.svh"

module quicksort_int_ascending_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [qsi_pkg::DATA_BITS-1:0] value,
    input  wire logic                                 is_last,
    output logic                                      strobe,
    output logic signed [qsi_pkg::DATA_BITS-1:0]      sorted_value,
    output logic                                      end_of_run,
    output logic                                      overflowed
);

    qsi_pkg::state_t state_reg, state_next;

    qsi_pkg::cnt_t  count_reg, count_next;
    logic           ovf_reg, ovf_next;
    qsi_pkg::cnt_t  sp_reg, sp_next;
    qsi_pkg::addr_t lo_reg, lo_next;
    qsi_pkg::addr_t hi_reg, hi_next;
    qsi_pkg::addr_t j_reg, j_next;
    qsi_pkg::addr_t si_reg, si_next;
    qsi_pkg::addr_t k_reg, k_next;
    qsi_pkg::word_t pivot_reg, pivot_next;
    qsi_pkg::word_t aj_reg, aj_next;
    logic           strobe_reg, strobe_next;
    logic           end_reg, end_next;
    logic           ovf_out_reg, ovf_out_next;

    // Item RAM ports.
    logic           item_we;
    qsi_pkg::addr_t item_waddr;
    qsi_pkg::word_t item_wdata;
    qsi_pkg::addr_t item_raddr;
    qsi_pkg::word_t item_rdata;

    // Range stack RAM ports.
    logic           stk_we;
    qsi_pkg::addr_t stk_waddr;
    qsi_pkg::range_t stk_wdata;
    qsi_pkg::addr_t stk_raddr;
    qsi_pkg::range_t stk_rdata;

    // Shared comparator and loop conditions.
    logic           less;
    logic           loop_more;
    logic           emit_done;
    logic           stack_room;
    qsi_pkg::cnt_t  j_plus;

    qsi_ram #(
        .WIDTH (qsi_pkg::WORD_BITS),
        .DEPTH (qsi_pkg::STORE_DEPTH)
    ) u_item_ram (
        .clk   (clk),
        .we    (item_we),
        .waddr (item_waddr),
        .wdata (item_wdata),
        .raddr (item_raddr),
        .rdata (item_rdata)
    );

    qsi_ram #(
        .WIDTH (qsi_pkg::RANGE_BITS),
        .DEPTH (qsi_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // The one signed comparator, and the conditions that steer the sequencer.
    assign less       = $signed(item_rdata) < $signed(pivot_reg);
    assign j_plus     = {1'b0, j_reg} + qsi_pkg::cnt_t'(1);
    assign loop_more  = j_plus < {1'b0, hi_reg};
    assign emit_done  = ({1'b0, k_reg} + qsi_pkg::cnt_t'(1)) == count_reg;
    assign stack_room = sp_reg < qsi_pkg::cnt_t'(qsi_pkg::STACK_DEPTH);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qsi_pkg::ST_LOAD:
            begin
                if (start && is_last)
                begin
                    state_next = qsi_pkg::ST_INIT;
                end
            end
            qsi_pkg::ST_INIT:
            begin
                state_next = (count_reg >= qsi_pkg::cnt_t'(2)) ? qsi_pkg::ST_POP
                                                                : qsi_pkg::ST_EMIT;
            end
            qsi_pkg::ST_POP:
            begin
                state_next = (sp_reg == '0) ? qsi_pkg::ST_EMIT : qsi_pkg::ST_RANGE;
            end
            qsi_pkg::ST_RANGE:
            begin
                state_next = (stk_rdata[qsi_pkg::RANGE_BITS-1:qsi_pkg::ADDR_BITS]
                              >= stk_rdata[qsi_pkg::ADDR_BITS-1:0])
                             ? qsi_pkg::ST_POP : qsi_pkg::ST_PIVOT;
            end
            qsi_pkg::ST_PIVOT:
            begin
                state_next = qsi_pkg::ST_CMP;
            end
            qsi_pkg::ST_CMP:
            begin
                if (less)
                begin
                    state_next = qsi_pkg::ST_SWAP_RD;
                end
                else if (!loop_more)
                begin
                    state_next = qsi_pkg::ST_FIN_A;
                end
            end
            qsi_pkg::ST_SWAP_RD:
            begin
                state_next = qsi_pkg::ST_SWAP_WR;
            end
            qsi_pkg::ST_SWAP_WR:
            begin
                state_next = loop_more ? qsi_pkg::ST_CMP : qsi_pkg::ST_FIN_A;
            end
            qsi_pkg::ST_FIN_A:
            begin
                state_next = qsi_pkg::ST_FIN_B;
            end
            qsi_pkg::ST_FIN_B:
            begin
                state_next = qsi_pkg::ST_PUSH_LO;
            end
            qsi_pkg::ST_PUSH_LO:
            begin
                state_next = qsi_pkg::ST_PUSH_HI;
            end
            qsi_pkg::ST_PUSH_HI:
            begin
                state_next = qsi_pkg::ST_POP;
            end
            qsi_pkg::ST_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = qsi_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = qsi_pkg::ST_LOAD;
            end
        endcase
    end

    // Datapath controls and register updates for each state.
    always_comb
    begin
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        sp_next      = sp_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        j_next       = j_reg;
        si_next      = si_reg;
        k_next       = k_reg;
        pivot_next   = pivot_reg;
        aj_next      = aj_reg;
        strobe_next  = 1'b0;
        end_next     = end_reg;
        ovf_out_next = ovf_out_reg;
        item_we      = 1'b0;
        item_waddr   = si_reg;
        item_wdata   = aj_reg;
        item_raddr   = k_reg;
        stk_we       = 1'b0;
        stk_waddr    = sp_reg[qsi_pkg::ADDR_BITS-1:0];
        stk_wdata    = {lo_reg, hi_reg};
        stk_raddr    = sp_reg[qsi_pkg::ADDR_BITS-1:0];
        unique case (state_reg)
            qsi_pkg::ST_LOAD:
            begin
                // Store the beat, or drop it and flag overflow when full.
                if (start)
                begin
                    if (count_reg < qsi_pkg::cnt_t'(qsi_pkg::MAX_ITEMS))
                    begin
                        item_we    = 1'b1;
                        item_waddr = count_reg[qsi_pkg::ADDR_BITS-1:0];
                        item_wdata = value[qsi_pkg::WORD_BITS-1:0];
                        count_next = count_reg + qsi_pkg::cnt_t'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            qsi_pkg::ST_INIT:
            begin
                // Push the whole set as the first range.
                k_next = '0;
                if (count_reg >= qsi_pkg::cnt_t'(2))
                begin
                    stk_we    = 1'b1;
                    stk_waddr = '0;
                    stk_wdata = {qsi_pkg::addr_t'(0),
                                 qsi_pkg::addr_t'(count_reg - qsi_pkg::cnt_t'(1))};
                    sp_next   = qsi_pkg::cnt_t'(1);
                end
            end
            qsi_pkg::ST_POP:
            begin
                k_next = '0;
                if (sp_reg != '0)
                begin
                    sp_next   = sp_reg - qsi_pkg::cnt_t'(1);
                    stk_raddr = sp_next[qsi_pkg::ADDR_BITS-1:0];
                end
            end
            qsi_pkg::ST_RANGE:
            begin
                // Unpack the range and fetch its pivot.
                lo_next    = stk_rdata[qsi_pkg::RANGE_BITS-1:qsi_pkg::ADDR_BITS];
                hi_next    = stk_rdata[qsi_pkg::ADDR_BITS-1:0];
                item_raddr = stk_rdata[qsi_pkg::ADDR_BITS-1:0];
            end
            qsi_pkg::ST_PIVOT:
            begin
                pivot_next = item_rdata;
                j_next     = lo_reg;
                si_next    = lo_reg;
                item_raddr = lo_reg;
            end
            qsi_pkg::ST_CMP:
            begin
                // Element j is on the read port: swap it left, or step on.
                if (less)
                begin
                    aj_next    = item_rdata;
                    item_raddr = si_reg;
                end
                else if (loop_more)
                begin
                    j_next     = j_plus[qsi_pkg::ADDR_BITS-1:0];
                    item_raddr = j_plus[qsi_pkg::ADDR_BITS-1:0];
                end
                else
                begin
                    item_raddr = si_reg;
                end
            end
            qsi_pkg::ST_SWAP_RD:
            begin
                item_we    = 1'b1;
                item_waddr = j_reg;
                item_wdata = item_rdata;
            end
            qsi_pkg::ST_SWAP_WR:
            begin
                item_we    = 1'b1;
                item_waddr = si_reg;
                item_wdata = aj_reg;
                si_next    = si_reg + qsi_pkg::addr_t'(1);
                if (loop_more)
                begin
                    j_next     = j_plus[qsi_pkg::ADDR_BITS-1:0];
                    item_raddr = j_plus[qsi_pkg::ADDR_BITS-1:0];
                end
                else
                begin
                    item_raddr = si_next;
                end
            end
            qsi_pkg::ST_FIN_A:
            begin
                // Move the element at the split point to the range end.
                item_we    = 1'b1;
                item_waddr = hi_reg;
                item_wdata = item_rdata;
            end
            qsi_pkg::ST_FIN_B:
            begin
                item_we    = 1'b1;
                item_waddr = si_reg;
                item_wdata = pivot_reg;
            end
            qsi_pkg::ST_PUSH_LO:
            begin
                // Left part, when it holds at least two elements.
                if (({1'b0, si_reg} > ({1'b0, lo_reg} + qsi_pkg::cnt_t'(1))) && stack_room)
                begin
                    stk_we    = 1'b1;
                    stk_wdata = {lo_reg, si_reg - qsi_pkg::addr_t'(1)};
                    sp_next   = sp_reg + qsi_pkg::cnt_t'(1);
                end
            end
            qsi_pkg::ST_PUSH_HI:
            begin
                // Right part, when it holds at least two elements.
                if ((({1'b0, si_reg} + qsi_pkg::cnt_t'(1)) < {1'b0, hi_reg}) && stack_room)
                begin
                    stk_we    = 1'b1;
                    stk_wdata = {si_reg + qsi_pkg::addr_t'(1), hi_reg};
                    sp_next   = sp_reg + qsi_pkg::cnt_t'(1);
                end
            end
            qsi_pkg::ST_EMIT:
            begin
                // One read per cycle; flags travel alongside the read.
                item_raddr   = k_reg;
                strobe_next  = 1'b1;
                end_next     = emit_done;
                ovf_out_next = ovf_reg;
                k_next       = k_reg + qsi_pkg::addr_t'(1);
                if (emit_done)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    sp_next    = '0;
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= qsi_pkg::ST_LOAD;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            sp_reg     <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            sp_reg     <= sp_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        j_reg       <= j_next;
        si_reg      <= si_next;
        k_reg       <= k_next;
        pivot_reg   <= pivot_next;
        aj_reg      <= aj_next;
        end_reg     <= end_next;
        ovf_out_reg <= ovf_out_next;
    end

    // Ports.
    assign busy         = (state_reg != qsi_pkg::ST_LOAD);
    assign strobe       = strobe_reg;
    assign sorted_value = qsi_pkg::DATA_BITS'(item_rdata);
    assign end_of_run   = end_reg;
    assign overflowed   = ovf_out_reg;

    // Checks on the sequencer.
    `QSI_ASSERT_IMP(a_count_cap, 1'b1, count_reg <= qsi_pkg::cnt_t'(qsi_pkg::MAX_ITEMS),
        "item count beyond capacity")
    `QSI_ASSERT_IMP(a_stack_cap, 1'b1, sp_reg <= qsi_pkg::cnt_t'(qsi_pkg::STACK_DEPTH),
        "range stack pointer beyond depth")
    `QSI_ASSERT_IMP(a_scan_order, state_reg == qsi_pkg::ST_CMP,
        (si_reg <= j_reg) && (j_reg < hi_reg), "partition indices out of order")
    `QSI_ASSERT_NEXT(a_close_busy, start && !busy && is_last, busy,
        "closing beat did not start the sort")
    `QSI_ASSERT_NEXT(a_run_ends, strobe && end_of_run, !strobe,
        "result strobe after the final result")

endmodule

`default_nettype wire

// ===== design/qsi_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module qsi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== verif/tb_quicksort_int_ascending_top.sv =====
// Self-checking testbench for the quicksort block against a sorting predictor.
`timescale 1ns / 100ps

module tb_quicksort_int_ascending_top;

    localparam int DATA_BITS      = qsi_pkg::DATA_BITS;
    localparam int MAX_ITEMS      = qsi_pkg::MAX_ITEMS;
    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 8;
    // A worst-case 64-item sort runs with nothing accepted, so the limit must cover it.
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int TAIL_CYCLES    = 200;
    localparam int GAP_MIN        = 1;
    localparam int GAP_MAX        = 18;
    localparam int RANDOM_ITEMS   = 230;
    localparam int TOTAL_ITEMS    = 270;

    // How the values of one set are chosen.
    typedef enum int {
        FILL_RANDOM,
        FILL_NARROW,
        FILL_ASCENDING,
        FILL_DESCENDING
    } fill_t;

    // One sorted result beat as the block should present it.
    typedef struct {
        logic signed [DATA_BITS-1:0] sorted_value;
        logic                        end_of_run;
        logic                        overflowed;
    } sorted_beat_t;

    // Collects the integers of a set, sorts them on the closing beat and checks the output.
    class ascending_sort_board;
        logic signed [DATA_BITS-1:0] held[MAX_ITEMS];
        int                          held_count;
        bit                          dropped;
        sorted_beat_t                expected_sorted_q[$];
        int                          mismatches;

        function new();
            held_count = 0;
            dropped    = 0;
            mismatches = 0;
        endfunction

        // Lomuto partition: the last element is the pivot, smaller ones move left.
        function int split_range(int lo, int hi);
            logic signed [DATA_BITS-1:0] pivot;
            logic signed [DATA_BITS-1:0] spare;
            int                          slot;
            int                          j;
            pivot = held[hi];
            slot  = lo;
            for (j = lo; j < hi; j++)
            begin
                if (held[j] < pivot)
                begin
                    spare      = held[slot];
                    held[slot] = held[j];
                    held[j]    = spare;
                    slot++;
                end
            end
            spare      = held[slot];
            held[slot] = held[hi];
            held[hi]   = spare;
            return slot;
        endfunction

        // Quicksort over the held integers with an explicit range stack.
        function void sort_held();
            int range_lo[MAX_ITEMS];
            int range_hi[MAX_ITEMS];
            int depth;
            int lo;
            int hi;
            int p;
            depth = 0;
            if (held_count >= 2)
            begin
                range_lo[0] = 0;
                range_hi[0] = held_count - 1;
                depth       = 1;
            end
            while (depth > 0)
            begin
                depth--;
                lo = range_lo[depth];
                hi = range_hi[depth];
                if (lo < hi)
                begin
                    p = split_range(lo, hi);
                    if (p > lo + 1 && depth < MAX_ITEMS)
                    begin
                        range_lo[depth] = lo;
                        range_hi[depth] = p - 1;
                        depth++;
                    end
                    if (p + 1 < hi && depth < MAX_ITEMS)
                    begin
                        range_lo[depth] = p + 1;
                        range_hi[depth] = hi;
                        depth++;
                    end
                end
            end
        endfunction

        // Called for every accepted input beat.
        function void note_beat(logic signed [DATA_BITS-1:0] v, logic last);
            sorted_beat_t beat;
            int           k;
            if (held_count < MAX_ITEMS)
            begin
                held[held_count] = v;
                held_count++;
            end
            else
            begin
                dropped = 1'b1;
            end
            if (last)
            begin
                sort_held();
                for (k = 0; k < held_count; k++)
                begin
                    beat.sorted_value = held[k];
                    beat.end_of_run   = (k == held_count - 1);
                    beat.overflowed   = dropped;
                    expected_sorted_q.push_back(beat);
                end
                held_count = 0;
                dropped    = 1'b0;
            end
        endfunction

        // Called for every result beat; compares it with the oldest expectation.
        function void check_result(logic signed [DATA_BITS-1:0] sv, logic eor, logic ovf);
            sorted_beat_t want;
            if (expected_sorted_q.size() == 0)
            begin
                $error("unexpected result beat: sorted_value %0d", sv);
                mismatches++;
                return;
            end
            want = expected_sorted_q.pop_front();
            if (sv !== want.sorted_value)
            begin
                $error("sorted_value: expected %0d, got %0d", want.sorted_value, sv);
                mismatches++;
            end
            if (eor !== want.end_of_run)
            begin
                $error("end_of_run: expected %0b, got %0b", want.end_of_run, eor);
                mismatches++;
            end
            if (ovf !== want.overflowed)
            begin
                $error("overflowed: expected %0b, got %0b", want.overflowed, ovf);
                mismatches++;
            end
        endfunction

        // Any expectation still waiting at the end is a failure.
        function void flush_leftovers();
            sorted_beat_t want;
            while (expected_sorted_q.size() != 0)
            begin
                want = expected_sorted_q.pop_front();
                $error("missing result beat: sorted_value %0d", want.sorted_value);
                mismatches++;
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic signed [DATA_BITS-1:0] value = '0;
    logic                        is_last = 1'b0;
    logic                        strobe;
    logic signed [DATA_BITS-1:0] sorted_value;
    logic                        end_of_run;
    logic                        overflowed;

    ascending_sort_board board = new();
    int                  items_sent = 0;
    int                  quiet_cycles = 0;

    quicksort_int_ascending_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .is_last      (is_last),
        .strobe       (strobe),
        .sorted_value (sorted_value),
        .end_of_run   (end_of_run),
        .overflowed   (overflowed)
    );

    // Free-running clock, 8 ns period.
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Every result beat is checked at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            board.check_result(sorted_value, end_of_run, overflowed);
        end
    end

    // Watchdog: ends the run if nothing is accepted or emitted for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one input beat and holds it until the block accepts it.
    task automatic send_beat(input logic signed [DATA_BITS-1:0] v, input logic last);
        start   <= 1'b1;
        value   <= v;
        is_last <= last;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        board.note_beat(v, last);
        items_sent++;
    endtask

    // Holds start low for a burst, with junk on the payload ports.
    task automatic pause_sender(input int cycles);
        start   <= 1'b0;
        value   <= $urandom;
        is_last <= $urandom_range(0, 1);
        repeat (cycles) @(posedge clk);
    endtask

    // Holds start low until every expected result beat has come back.
    task automatic wait_for_drain();
        start <= 1'b0;
        while (board.expected_sorted_q.size() != 0) @(posedge clk);
    endtask

    // Sends one whole set; gaps may fall between beats and after the closing one.
    task automatic send_set(input int size, input fill_t fill, input bit gaps);
        logic signed [DATA_BITS-1:0] v;
        int                          i;
        for (i = 0; i < size; i++)
        begin
            case (fill)
                FILL_NARROW:     v = int'($urandom_range(0, 6)) - 3;
                FILL_ASCENDING:  v = -1280000000 + i * 40000000;
                FILL_DESCENDING: v = 1280000000 - i * 40000000;
                default:
                begin
                    v = $urandom;
                    if ($urandom_range(0, 9) == 0)
                    begin
                        v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                    end
                end
            endcase
            send_beat(v, i == size - 1);
            if (gaps && $urandom_range(0, 3) == 0)
            begin
                pause_sender($urandom_range(GAP_MIN, GAP_MAX));
            end
        end
    endtask

    // Sends a small set of random shape.
    task automatic send_small_set(input bit gaps);
        fill_t fill;
        fill = fill_t'($urandom_range(0, 3));
        send_set($urandom_range(1, 12), fill, gaps);
    endtask

    // Stimulus: reset, directed sets, random sets, then a calm stretch.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-item sets at both extremes.
        send_beat(32'sh8000_0000, 1'b1);
        send_beat(32'sh7FFF_FFFF, 1'b1);
        // Extremes, zero and minus one mixed in one set.
        send_beat(32'sh7FFF_FFFF, 1'b0);
        send_beat(32'sh8000_0000, 1'b0);
        send_beat(32'sh0000_0000, 1'b0);
        send_beat(32'shFFFF_FFFF, 1'b0);
        send_beat(32'sh0000_0001, 1'b1);
        // All equal, so every comparison with the pivot fails.
        send_beat(32'sd3, 1'b0);
        send_beat(32'sd3, 1'b0);
        send_beat(32'sd3, 1'b1);
        // Two-item sets in both orders.
        send_beat(32'sd2, 1'b0);
        send_beat(32'sd1, 1'b1);
        send_beat(32'sd1, 1'b0);
        send_beat(32'sd2, 1'b1);
        // Alternating signs with duplicates.
        send_beat(32'sd5, 1'b0);
        send_beat(-32'sd5, 1'b0);
        send_beat(32'sd5, 1'b0);
        send_beat(-32'sd5, 1'b0);
        send_beat(32'sd0, 1'b1);
        wait_for_drain();

        // Random small sets, each either gapped or back to back.
        while (items_sent < 60)
        begin
            send_small_set($urandom_range(0, 2) != 0);
        end

        // A full store in ascending order: the slowest partition pattern.
        send_set(MAX_ITEMS, FILL_ASCENDING, 1'b1);
        wait_for_drain();
        // The closing beat finds the store full and is dropped, yet closes the set.
        send_set(MAX_ITEMS + 1, FILL_RANDOM, 1'b1);
        // Several beats dropped from a descending set.
        send_set(MAX_ITEMS + 6, FILL_DESCENDING, 1'b0);
        wait_for_drain();

        while (items_sent < RANDOM_ITEMS)
        begin
            send_small_set($urandom_range(0, 2) != 0);
        end

        // Final stretch with no idling at all.
        while (items_sent < TOTAL_ITEMS)
        begin
            send_small_set(1'b0);
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        board.flush_leftovers();
        if (board.mismatches == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
